// File: rtl/afsc_pkg.sv
// Package of shared types, constants and functions for the archive field serializer.
package afsc_pkg;

	// Input commands
	localparam logic [2:0] CMD_BYTE    = 3'd0;
	localparam logic [2:0] CMD_WORD32  = 3'd1;
	localparam logic [2:0] CMD_WORD64  = 3'd2;
	localparam logic [2:0] CMD_NUMBER  = 3'd3;
	localparam logic [2:0] CMD_RESTART = 3'd4;

	// Write modes
	localparam logic [1:0] MODE_COUNT   = 2'd0;
	localparam logic [1:0] MODE_EMIT_CRC = 2'd1;
	localparam logic [1:0] MODE_EMIT    = 2'd2;

	// Work kinds handed from front to back
	localparam logic [1:0] KIND_EMIT    = 2'd0;
	localparam logic [1:0] KIND_COUNT   = 2'd1;
	localparam logic [1:0] KIND_RESTART = 2'd2;
	localparam logic [1:0] KIND_NOP     = 2'd3;

	localparam int          MAX_BYTES  = 9;
	localparam int          QUEUE_DEPTH = 2;
	localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT   = 32'hFFFFFFFF;
	localparam logic [7:0]  NUM_LEAD_BIT = 8'h80;

	// One classified item
	typedef struct packed {
		logic [1:0]                 kind;
		logic [3:0]                 len;
		logic [MAX_BYTES-1:0][7:0]  bytes;
	} afsc_entry_t;

	// Reflected CRC-32 over one byte
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Saturating add of a small length to the 48-bit count
	function automatic logic [47:0] sat_add(input logic [47:0] cnt, input logic [3:0] n);
		logic [48:0] sum;
		sum = {1'b0, cnt} + {45'd0, n};
		return sum[48] ? {48{1'b1}} : sum[47:0];
	endfunction

endpackage

// File: rtl/afsc_front.sv
// Front end: accepts commands, builds the byte image and classifies the work.
module afsc_front import afsc_pkg::*; (
	input  logic        s_tvalid,
	input  logic [2:0]  s_tuser,
	input  logic [63:0] s_tdata,
	input  logic [1:0]  mode,
	output logic        push,
	output afsc_entry_t push_ent
);

	logic [7:0][7:0] vb;
	logic [3:0]      extra;
	logic [7:0]      lead;
	logic [7:0]      first;

	assign vb = s_tdata;

	// Find the count of extra bytes of a 7z number
	always_comb begin
		extra = 4'd8;
		for (int e = 7; e >= 0; e--) begin
			if ((s_tdata >> (7 * (e + 1))) == 64'd0) begin
				extra = 4'(e);
			end
		end
		lead  = ~(8'hFF >> extra);
		first = lead | (extra[3] ? 8'd0 : vb[extra[2:0]]);
	end

	// Classify and build the byte image
	always_comb begin
		push_ent.bytes = {8'd0, s_tdata};
		push_ent.len   = 4'd1;
		push_ent.kind  = KIND_NOP;
		case (s_tuser)
			CMD_BYTE: begin
				push_ent.len  = 4'd1;
				push_ent.kind = KIND_EMIT;
			end
			CMD_WORD32: begin
				push_ent.len  = 4'd4;
				push_ent.kind = KIND_EMIT;
			end
			CMD_WORD64: begin
				push_ent.len  = 4'd8;
				push_ent.kind = KIND_EMIT;
			end
			CMD_NUMBER: begin
				push_ent.bytes = {s_tdata, first};
				push_ent.len   = extra + 4'd1;
				push_ent.kind  = KIND_EMIT;
			end
			CMD_RESTART: begin
				push_ent.kind = KIND_RESTART;
			end
			default: begin
				push_ent.kind = KIND_NOP;
			end
		endcase
		// Count-only mode folds the bytes into a single count step
		if (push_ent.kind == KIND_EMIT && mode == MODE_COUNT) begin
			push_ent.kind = KIND_COUNT;
		end
	end

	assign push = s_tvalid;

endmodule

// File: rtl/afsc_queue.sv
// Two-entry queue between the front and the back.
module afsc_queue import afsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  afsc_entry_t push_ent,
	output logic        push_ready,
	input  logic        pop,
	output logic        head_valid,
	output afsc_entry_t head_ent
);

	afsc_entry_t ent_q [QUEUE_DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;
	logic        do_push;
	logic        do_pop;

	assign push_ready = (fill_q != 2'(QUEUE_DEPTH));
	assign head_valid = (fill_q != 2'd0);
	assign head_ent   = ent_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule

// File: rtl/afsc_back.sv
// Back end: emits bytes one per cycle while m_tready does not hold the output, updates the CRC and the byte count.
module afsc_back import afsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  mode,
	input  logic        head_valid,
	input  afsc_entry_t head_ent,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	logic [31:0] crc_q;
	logic [47:0] cnt_q;
	logic [3:0]  idx_q;
	logic        m_tvalid_q;
	logic [7:0]  byte_q;
	logic        bvalid_q;
	logic        last_q;
	logic [31:0] digest_q;
	logic [47:0] count_q;

	logic        step;
	logic [7:0]  cur_byte;
	logic [31:0] crc_n;
	logic [47:0] cnt_n;
	logic [7:0]  res_byte;
	logic        res_bvalid;
	logic        res_last;

	assign step     = head_valid && (!m_tvalid_q || m_tready);
	assign cur_byte = head_ent.bytes[idx_q];
	assign pop      = step && res_last;

	// Work out the next result
	always_comb begin
		crc_n      = crc_q;
		cnt_n      = cnt_q;
		res_byte   = 8'd0;
		res_bvalid = 1'b0;
		res_last   = 1'b1;
		case (head_ent.kind)
			KIND_EMIT: begin
				if (mode == MODE_EMIT_CRC) begin
					crc_n = crc_byte(crc_q, cur_byte);
				end
				cnt_n      = sat_add(cnt_q, 4'd1);
				res_byte   = cur_byte;
				res_bvalid = 1'b1;
				res_last   = (idx_q == head_ent.len - 4'd1);
			end
			KIND_COUNT: begin
				cnt_n = sat_add(cnt_q, head_ent.len);
			end
			KIND_RESTART: begin
				crc_n = CRC_INIT;
				cnt_n = 48'd0;
			end
			default: begin
				crc_n = crc_q;
			end
		endcase
	end

	// Hold running state and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q      <= CRC_INIT;
			cnt_q      <= 48'd0;
			idx_q      <= 4'd0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (step) begin
				crc_q      <= crc_n;
				cnt_q      <= cnt_n;
				idx_q      <= res_last ? 4'd0 : idx_q + 4'd1;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (step) begin
			byte_q   <= res_byte;
			bvalid_q <= res_bvalid;
			last_q   <= res_last;
			digest_q <= ~crc_n;
			count_q  <= cnt_n;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {count_q, digest_q, byte_q};
	assign m_tuser  = bvalid_q;
	assign m_tlast  = last_q;

endmodule

// File: rtl/archive_field_serializer_crc.sv
// Top level of the archive field serializer with 7z number encoding and CRC-32.
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: cmd[2:0]; tdata: field_value[63:0]
// m_*      out  m_tvalid/m_tready  tdata: out_byte, crc_digest, byte_count; tuser: byte_valid;
//                                  tlast: last
// cfg_*    in   cfg_wen            cfg_wdata: write_mode[1:0]
//
// An item produces one transfer per cycle from the back end unless m_tready holds it: one
// per byte of the item when emitting (1 to 9), one for count-only, restart and unused commands.
// The byte sequencer with its one-byte CRC step sets this rate.
// The front accepts an item in any cycle the two-entry queue has room, so intake continues
// while the output register waits on m_tready.
// Reset gives write_mode 1, CRC all ones, byte count zero, queue and output empty.
module archive_field_serializer_crc import afsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // cmd[2:0]
	input  logic [63:0] s_tdata,   // field_value[63:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,   // out_byte[7:0], crc_digest[39:8], byte_count[87:40]
	output logic        m_tuser,   // byte_valid
	output logic        m_tlast
);

	logic [1:0]  mode_q;
	logic        push;
	afsc_entry_t push_ent;
	logic        head_valid;
	afsc_entry_t head_ent;
	logic        pop;

	// Hold the write mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_EMIT_CRC;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	afsc_front u_front (
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.mode     (mode_q),
		.push     (push),
		.push_ent (push_ent)
	);

	afsc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ent   (push_ent),
		.push_ready (s_tready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_ent   (head_ent)
	);

	afsc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode       (mode_q),
		.head_valid (head_valid),
		.head_ent   (head_ent),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

// File: tb/archive_field_serializer_crc_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the archive field serializer with 7z numbers and CRC-32.
module archive_field_serializer_crc_test;
	import afsc_pkg::*;

	localparam logic [1:0]  MODE_UNUSED    = 2'd3;
	localparam logic [2:0]  CMD_UNUSED_LO  = 3'd5;
	localparam logic [2:0]  CMD_UNUSED_HI  = 3'd7;
	localparam logic [47:0] COUNT_CEIL     = 48'hFFFF_FFFF_FFFF;
	localparam int          STALL_LIMIT    = 4000;
	localparam int          SETTLE_CYCLES  = 24;
	localparam int          REPORT_LIMIT   = 10;
	localparam int          PHASE_ITEMS    = 21;
	localparam int          NUM_PHASES     = 6;

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] value;
	} field_item_t;

	typedef struct {
		logic [7:0]  data_byte;
		logic        byte_flag;
		logic        end_flag;
		logic [31:0] digest;
		logic [47:0] total;
	} stream_beat_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_wen   = 1'b0;
	logic [1:0]  cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [2:0]  s_tuser   = '0;
	logic [63:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [87:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	// Predictor state: running CRC, byte total and the current write mode
	logic [31:0] crc_reg     = CRC_INIT;
	logic [47:0] byte_total  = '0;
	logic [1:0]  mode_reg    = MODE_EMIT_CRC;

	field_item_t  pending_fields[$];
	stream_beat_t expected_beats[$];

	logic steady = 1'b0;
	int   mismatches   = 0;
	int   items_sent   = 0;
	int   numbers_sent = 0;
	int   restarts     = 0;
	int   beats_seen   = 0;
	int   mode_writes  = 0;
	int   stall_cycles = 0;

	archive_field_serializer_crc DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #6 clk = ~clk;

	// Advance the reflected CRC-32 by one byte, bit by bit
	function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] data);
		logic [31:0] c;
		c = crc ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
		end
		return c;
	endfunction

	function automatic logic [47:0] count_up(input logic [47:0] total, input int n);
		return (total > COUNT_CEIL - 48'(n)) ? COUNT_CEIL : total + 48'(n);
	endfunction

	// Serialize one accepted item and queue the transfers it should produce
	task automatic serialize_expected(input logic [2:0] cmd, input logic [63:0] value);
		logic [7:0]   seq [0:8];
		logic [7:0]   first;
		logic [7:0]   mask;
		logic [63:0]  high;
		logic         found;
		int           extra;
		int           n;
		int           i;
		stream_beat_t b;
		n = 0;
		case (cmd)
			CMD_BYTE: begin
				seq[0] = value[7:0];
				n = 1;
			end
			CMD_WORD32, CMD_WORD64: begin
				n = (cmd == CMD_WORD32) ? 4 : 8;
				for (i = 0; i < n; i++) seq[i] = value[8*i +: 8];
			end
			CMD_NUMBER: begin
				// leading ones in the first byte count the extra bytes
				first = '0;
				mask = NUM_LEAD_BIT;
				found = 1'b0;
				extra = 8;
				for (i = 0; i < 8; i++) begin
					if (!found) begin
						if (value < (64'd1 << (7 * (i + 1)))) begin
							high = value >> (8 * i);
							first = first | high[7:0];
							extra = i;
							found = 1'b1;
						end else begin
							first = first | mask;
							mask = mask >> 1;
						end
					end
				end
				seq[0] = first;
				for (i = 0; i < extra; i++) seq[i + 1] = value[8*i +: 8];
				n = extra + 1;
				numbers_sent++;
			end
			default: n = 0;
		endcase
		if (cmd == CMD_RESTART) begin
			crc_reg = CRC_INIT;
			byte_total = '0;
			restarts++;
		end
		if (cmd > CMD_NUMBER || mode_reg == MODE_COUNT) begin
			// one status-only transfer
			if (cmd <= CMD_NUMBER) byte_total = count_up(byte_total, n);
			b.data_byte = '0;
			b.byte_flag = 1'b0;
			b.end_flag = 1'b1;
			b.digest = ~crc_reg;
			b.total = byte_total;
			expected_beats.insert(expected_beats.size(), b);
		end else begin
			for (i = 0; i < n; i++) begin
				if (mode_reg == MODE_EMIT_CRC) crc_reg = crc_step(crc_reg, seq[i]);
				byte_total = count_up(byte_total, 1);
				b.data_byte = seq[i];
				b.byte_flag = 1'b1;
				b.end_flag = (i == n - 1);
				b.digest = ~crc_reg;
				b.total = byte_total;
				expected_beats.insert(expected_beats.size(), b);
			end
		end
	endtask

	// Sender: hold the item until the transfer, then load the next one or idle
	always @(posedge clk or negedge arst_n) begin
		field_item_t it;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tuser <= '0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				serialize_expected(s_tuser, s_tdata);
				items_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_fields.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
					it = pending_fields.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= it.cmd;
					s_tdata <= it.value;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: compare each output transfer with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		stream_beat_t exp_b;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				beats_seen++;
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: unexpected transfer: tdata=%h user=%b last=%b",
							$realtime, m_tdata, m_tuser, m_tlast);
				end else begin
					exp_b = expected_beats.pop_front();
					if (m_tdata[7:0] !== exp_b.data_byte || m_tuser !== exp_b.byte_flag ||
					    m_tlast !== exp_b.end_flag || m_tdata[39:8] !== exp_b.digest ||
					    m_tdata[87:40] !== exp_b.total) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("%0t: expected byte=%h valid=%b last=%b crc=%h count=%0d",
								$realtime, exp_b.data_byte, exp_b.byte_flag,
								exp_b.end_flag, exp_b.digest, exp_b.total);
							$display("%0t:      got byte=%h valid=%b last=%b crc=%h count=%0d",
								$realtime, m_tdata[7:0], m_tuser, m_tlast,
								m_tdata[39:8], m_tdata[87:40]);
						end
					end
				end
			end
			m_tready <= steady || ($urandom_range(99) >= 33);
		end
	end

	// Watchdog: end the run after too long without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles == STALL_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles, %0d results outstanding",
					STALL_LIMIT, expected_beats.size());
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic queue_item(input logic [2:0] cmd, input logic [63:0] value);
		field_item_t it;
		it.cmd = cmd;
		it.value = value;
		pending_fields.insert(pending_fields.size(), it);
	endtask

	// Hold until every queued item is sent and every expected result has arrived
	task automatic wait_drained();
		@(posedge clk);
		while (pending_fields.size() > 0 || s_tvalid || expected_beats.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_mode(input logic [1:0] mode);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= mode;
		@(posedge clk);
		cfg_wen <= 1'b0;
		mode_reg = mode;
		mode_writes++;
	endtask

	// Random item: mostly numbers of every encoded length, some words, restarts and junk
	task automatic queue_random_item();
		int          pick;
		logic [2:0]  cmd;
		logic [63:0] value;
		pick = $urandom_range(99);
		value = {$urandom, $urandom};
		if ($urandom_range(1)) value = value >> $urandom_range(63);
		if (pick < 18)      cmd = CMD_BYTE;
		else if (pick < 34) cmd = CMD_WORD32;
		else if (pick < 48) cmd = CMD_WORD64;
		else if (pick < 88) cmd = CMD_NUMBER;
		else if (pick < 95) cmd = CMD_RESTART;
		else                cmd = 3'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
		queue_item(cmd, value);
	endtask

	logic [1:0] mode_plan [NUM_PHASES] = '{MODE_COUNT, MODE_EMIT, MODE_UNUSED,
	                                       MODE_EMIT_CRC, MODE_COUNT, MODE_EMIT_CRC};

	initial begin
		int p;
		int k;
		// reset once
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, every command, every 7z number length
		queue_item(CMD_BYTE, 64'h0);
		queue_item(CMD_BYTE, 64'hFFFF_FFFF_FFFF_FF5A);
		queue_item(CMD_WORD32, 64'h0);
		queue_item(CMD_WORD32, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_item(CMD_WORD64, 64'h0123_4567_89AB_CDEF);
		queue_item(CMD_WORD64, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_item(CMD_NUMBER, 64'h0);
		queue_item(CMD_NUMBER, 64'h7F);
		queue_item(CMD_NUMBER, 64'h80);
		queue_item(CMD_NUMBER, 64'h3FFF);
		queue_item(CMD_NUMBER, 64'h4000);
		queue_item(CMD_NUMBER, 64'h1F_FFFF);
		queue_item(CMD_NUMBER, 64'h20_0000);
		queue_item(CMD_NUMBER, 64'h1000_0000);
		queue_item(CMD_NUMBER, 64'h8_0000_0000);
		queue_item(CMD_NUMBER, 64'h400_0000_0000);
		queue_item(CMD_NUMBER, 64'h2_0000_0000_0000);
		queue_item(CMD_NUMBER, 64'hFF_FFFF_FFFF_FFFF);
		queue_item(CMD_NUMBER, 64'h100_0000_0000_0000);
		queue_item(CMD_NUMBER, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_item(CMD_RESTART, 64'hDEAD_BEEF_0000_0001);
		queue_item(CMD_UNUSED_LO, 64'h1234);
		queue_item(3'd6, 64'h0);
		queue_item(CMD_UNUSED_HI, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_item(CMD_WORD32, 64'h8000_0001);

		// random phases, one mode setting each; the write waits for an idle block
		for (p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_mode(mode_plan[p]);
			steady = (p == 2);
			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (p == 3 && k == PHASE_ITEMS / 2) wait_drained();
				queue_random_item();
			end
		end

		// drain and let the pipeline settle
		wait_drained();
		steady = 1'b0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_beats.size() > 0) mismatches += expected_beats.size();

		$display("Run covered %0d items (%0d 7z numbers, %0d restarts) over %0d mode writes",
			items_sent, numbers_sent, restarts, mode_writes);
		$display("Checked %0d output transfers, %0d mismatching", beats_seen, mismatches);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
